// ===== hdl/chd_pkg.sv =====
// shared types and constants for the coordinate dedup hash table
`default_nettype none
package chd_pkg;

    // table geometry
    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SLOT_W     = IDX_W + 1;
    localparam int ID_W       = 12;
    localparam int LOAD_LIMIT = TABLE_SIZE * 7 / 10;

    // hash constants
    localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam int          XS_SHIFT  = 33;
    localparam int          SHL_AMT   = 6;
    localparam int          SHR_AMT   = 2;

    // one input item
    typedef struct packed {
        logic signed [63:0] coord_x;
        logic signed [63:0] coord_y;
        logic signed [63:0] coord_z;
    } t_key;

    // one result item
    typedef struct packed {
        logic [ID_W-1:0] point_id;
        logic            is_new;
        logic            table_full;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/coordinate_dedup_hash_table_core.sv =====
// top level: probe sequencer, slot table and key store of the coordinate dedup table
// After reset the block sweeps the 4096-entry slot table to empty, one slot per
// cycle, and holds busy high until the sweep is done. An item is then taken when
// start is high and busy is low. The hash runs on one shared 32x32 multiplier
// (three partial products per 64-bit multiply), then each probe steps through
// slot read, key read and compare using the single read ports of the slot and
// key memories. The result appears on o_result for exactly one cycle with
// o_done high and cannot be held off; busy drops in that same cycle. An absent
// key is refused with table_full once 7/10 of the slots are in use; keys
// already stored are still found.
`default_nettype none
module coordinate_dedup_hash_table_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire chd_pkg::t_key    i_key,
    output logic                  busy,
    output logic                  o_done,
    output chd_pkg::t_result      o_result
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_HASH     = 6'b000100,
        S_SLOT_RD  = 6'b001000,
        S_SLOT_CHK = 6'b010000,
        S_KEY_CHK  = 6'b100000
    } t_state;

    t_state                      r_state;
    logic [chd_pkg::IDX_W-1:0]   r_clr_addr;
    logic [chd_pkg::IDX_W-1:0]   r_pos;
    logic [chd_pkg::CNT_W-1:0]   r_probes;
    logic [chd_pkg::CNT_W-1:0]   r_count;
    chd_pkg::t_key               r_key;
    logic                        w_accept;
    logic                        w_hash_done;
    logic [31:0]                 w_hash;
    logic                        w_slot_we;
    logic [chd_pkg::IDX_W-1:0]   w_slot_waddr;
    logic [chd_pkg::SLOT_W-1:0]  w_slot_wdata;
    logic [chd_pkg::SLOT_W-1:0]  w_slot_rdata;
    logic                        w_key_we;
    logic [chd_pkg::IDX_W-1:0]   w_count_idx;
    chd_pkg::t_key               w_key_rdata;
    logic [chd_pkg::IDX_W-1:0]   w_slot_id;
    logic                        w_slot_valid;
    logic                        w_at_limit;

    assign busy         = (r_state != S_IDLE);
    assign w_accept     = start && !busy;
    assign w_slot_valid = w_slot_rdata[chd_pkg::IDX_W];
    assign w_slot_id    = w_slot_rdata[chd_pkg::IDX_W-1:0];
    assign w_count_idx  = r_count[chd_pkg::IDX_W-1:0];
    assign w_at_limit   = (r_count >= chd_pkg::CNT_W'(chd_pkg::LOAD_LIMIT));

    // slot and key writes: clearing sweep or append
    always_comb begin
        w_key_we     = (r_state == S_SLOT_CHK) && !w_slot_valid && !w_at_limit;
        w_slot_we    = (r_state == S_CLEAR) || w_key_we;
        w_slot_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pos;
        w_slot_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, w_count_idx};
    end

    // key hash unit
    chd_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_key),
        .o_done  (w_hash_done),
        .o_hash  (w_hash)
    );

    // slot table: {valid, id}
    chd_ram #(
        .DEPTH (chd_pkg::TABLE_SIZE),
        .WIDTH (chd_pkg::SLOT_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_waddr),
        .i_wr_data (w_slot_wdata),
        .i_rd_addr (r_pos),
        .o_rd_data (w_slot_rdata)
    );

    // stored keys indexed by id
    chd_ram #(
        .DEPTH (chd_pkg::TABLE_SIZE),
        .WIDTH ($bits(chd_pkg::t_key))
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_count_idx),
        .i_wr_data (r_key),
        .i_rd_addr (w_slot_id),
        .o_rd_data (w_key_rdata)
    );

    // probe sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            o_done     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == chd_pkg::IDX_W'(chd_pkg::TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_SLOT_RD;
                    end
                end
                S_SLOT_RD: r_state <= S_SLOT_CHK;
                S_SLOT_CHK: begin
                    if (!w_slot_valid) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (!w_at_limit) begin
                            r_count <= r_count + 1'b1;
                        end
                    end else begin
                        r_state <= S_KEY_CHK;
                    end
                end
                S_KEY_CHK: begin
                    if (w_key_rdata == r_key ||
                        r_probes == chd_pkg::CNT_W'(chd_pkg::TABLE_SIZE - 1)) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SLOT_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload and result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_key;
        end
        case (r_state)
            S_HASH: begin
                r_pos    <= w_hash[chd_pkg::IDX_W-1:0];
                r_probes <= '0;
            end
            S_SLOT_CHK: begin
                if (!w_slot_valid) begin
                    o_result.point_id   <= w_at_limit ? '0 : chd_pkg::ID_W'(w_count_idx);
                    o_result.is_new     <= !w_at_limit;
                    o_result.table_full <= w_at_limit;
                end
            end
            S_KEY_CHK: begin
                r_pos    <= r_pos + 1'b1;
                r_probes <= r_probes + 1'b1;
                if (w_key_rdata == r_key) begin
                    o_result.point_id   <= chd_pkg::ID_W'(w_slot_id);
                    o_result.is_new     <= 1'b0;
                    o_result.table_full <= 1'b0;
                end else begin
                    o_result.point_id   <= '0;
                    o_result.is_new     <= 1'b0;
                    o_result.table_full <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.is_new && o_result.table_full))
        else $error("result flagged both new and full");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= chd_pkg::CNT_W'(chd_pkg::LOAD_LIMIT))
        else $error("entry count beyond load limit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && !o_done)
        else $error("busy not raised after accepted item");

endmodule
`default_nettype wire

// ===== hdl/chd_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module chd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/chd_hash.sv =====
// key hash: golden-ratio combine and 64-bit finalizer on one shared 32x32 multiplier
`default_nettype none
module chd_hash (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire chd_pkg::t_key i_key,
    output logic               o_done,
    output logic [31:0]        o_hash
);

    typedef enum logic [6:0] {
        H_IDLE = 7'b0000001,
        H_C2   = 7'b0000010,
        H_X    = 7'b0000100,
        H_M0   = 7'b0001000,
        H_M1   = 7'b0010000,
        H_M2   = 7'b0100000,
        H_M3   = 7'b1000000
    } t_hstate;

    t_hstate     r_state;
    logic [1:0]  r_round;
    logic [63:0] r_v;
    logic [63:0] r_z;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] w_x;
    logic [63:0] w_y;
    logic [63:0] w_c1;
    logic [63:0] w_c2;
    logic [63:0] w_xs;
    logic [63:0] w_const;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;

    // combine steps
    assign w_x  = $unsigned(i_key.coord_x);
    assign w_y  = $unsigned(i_key.coord_y);
    assign w_c1 = w_x ^ (w_y + chd_pkg::GOLDEN + (w_x << chd_pkg::SHL_AMT)
                  + (w_x >> chd_pkg::SHR_AMT));
    assign w_c2 = r_v ^ (r_z + chd_pkg::GOLDEN + (r_v << chd_pkg::SHL_AMT)
                  + (r_v >> chd_pkg::SHR_AMT));
    assign w_xs = r_v ^ (r_v >> chd_pkg::XS_SHIFT);

    // shared multiplier operand select
    assign w_const = (r_round == 2'd0) ? chd_pkg::MIX_MUL_A : chd_pkg::MIX_MUL_B;
    assign w_mul_a = (r_state == H_M2) ? r_v[63:32] : r_v[31:0];
    assign w_mul_b = (r_state == H_M1) ? w_const[63:32] : w_const[31:0];
    assign w_mul_p = 64'(w_mul_a) * 64'(w_mul_b);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_round <= 2'd0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_state <= H_C2;
                        r_round <= 2'd0;
                    end
                end
                H_C2: r_state <= H_X;
                H_X: begin
                    if (r_round == 2'd2) begin
                        o_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_state <= H_M0;
                    end
                end
                H_M0: r_state <= H_M1;
                H_M1: r_state <= H_M2;
                H_M2: r_state <= H_M3;
                H_M3: begin
                    r_state <= H_X;
                    r_round <= r_round + 2'd1;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    r_v <= w_c1;
                    r_z <= $unsigned(i_key.coord_z);
                end
            end
            H_C2: r_v <= w_c2;
            H_X: begin
                r_v    <= w_xs;
                o_hash <= w_xs[31:0];
            end
            H_M0: r_prod <= w_mul_p;
            H_M1: begin
                r_acc  <= r_prod;
                r_prod <= w_mul_p;
            end
            H_M2: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_prod       <= w_mul_p;
            end
            H_M3: r_v <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== dv/coordinate_dedup_hash_table_core_chk.sv =====
// checker for the coordinate dedup table: predicts each lookup result and compares
`timescale 1ns / 100ps
`default_nettype none
module coordinate_dedup_hash_table_core_chk (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire chd_pkg::t_key    i_key,
    input  wire logic             o_done,
    input  wire chd_pkg::t_result o_result,
    output int                    fail_count,
    output int                    pending_count,
    output int                    stored_count,
    output int                    full_count
);

    // predicted table contents
    logic                      slot_used [chd_pkg::TABLE_SIZE];
    logic [chd_pkg::IDX_W-1:0] slot_id   [chd_pkg::TABLE_SIZE];
    logic [63:0]               key_x     [chd_pkg::TABLE_SIZE];
    logic [63:0]               key_y     [chd_pkg::TABLE_SIZE];
    logic [63:0]               key_z     [chd_pkg::TABLE_SIZE];
    int                        entries;
    chd_pkg::t_result          lookup_q[$];

    // golden-ratio combine and 64-bit finalizer, low index bits kept
    function automatic logic [chd_pkg::IDX_W-1:0] home_slot(input chd_pkg::t_key k);
        logic [63:0] h;
        h = k.coord_x;
        h = h ^ (k.coord_y + chd_pkg::GOLDEN + (h << chd_pkg::SHL_AMT)
                 + (h >> chd_pkg::SHR_AMT));
        h = h ^ (k.coord_z + chd_pkg::GOLDEN + (h << chd_pkg::SHL_AMT)
                 + (h >> chd_pkg::SHR_AMT));
        h = h ^ (h >> chd_pkg::XS_SHIFT);
        h = h * chd_pkg::MIX_MUL_A;
        h = h ^ (h >> chd_pkg::XS_SHIFT);
        h = h * chd_pkg::MIX_MUL_B;
        h = h ^ (h >> chd_pkg::XS_SHIFT);
        return h[chd_pkg::IDX_W-1:0];
    endfunction

    // probe, then either return the found id, append, or refuse
    function automatic chd_pkg::t_result lookup_point(input chd_pkg::t_key k);
        chd_pkg::t_result          r;
        logic [chd_pkg::IDX_W-1:0] pos;
        logic [chd_pkg::IDX_W-1:0] id;
        r = '0;
        pos = home_slot(k);
        while (slot_used[pos]) begin
            id = slot_id[pos];
            if (key_x[id] == k.coord_x && key_y[id] == k.coord_y &&
                key_z[id] == k.coord_z) begin
                r.point_id = id;
                return r;
            end
            pos = pos + 1'b1;
        end
        if ((entries + 1) * 10 > chd_pkg::TABLE_SIZE * 7) begin
            r.table_full = 1'b1;
            return r;
        end
        id = chd_pkg::IDX_W'(entries);
        key_x[id] = k.coord_x;
        key_y[id] = k.coord_y;
        key_z[id] = k.coord_z;
        slot_id[pos] = id;
        slot_used[pos] = 1'b1;
        entries = entries + 1;
        r.point_id = id;
        r.is_new = 1'b1;
        return r;
    endfunction

    // accept items, compare results
    always @(posedge i_clk) begin
        chd_pkg::t_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < chd_pkg::TABLE_SIZE; i++) slot_used[i] = 1'b0;
            entries = 0;
            lookup_q.delete();
            fail_count <= 0;
            full_count <= 0;
        end else begin
            if (o_done) begin
                if (lookup_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_result);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = lookup_q.pop_front();
                    if (exp_r !== o_result) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, o_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                exp_r = lookup_point(i_key);
                if (exp_r.table_full) full_count <= full_count + 1;
                lookup_q.push_back(exp_r);
            end
        end
        pending_count <= lookup_q.size();
        stored_count <= entries;
    end
endmodule
`default_nettype wire

// ===== dv/coordinate_dedup_hash_table_core_tb.sv =====
// testbench top: stimulus and verdict for the coordinate dedup table
`timescale 1ns / 100ps
`default_nettype none
module coordinate_dedup_hash_table_core_tb;

    localparam int CYCLE_LIMIT = 3000000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    chd_pkg::t_key    i_key = '0;
    logic             busy;
    logic             o_done;
    chd_pkg::t_result o_result;
    int               fail_count, pending_count, stored_count, full_count;
    int               cycles = 0;
    chd_pkg::t_key    known[$];

    always #5 i_clk = ~i_clk;

    coordinate_dedup_hash_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_key(i_key),
        .busy(busy), .o_done(o_done), .o_result(o_result)
    );

    coordinate_dedup_hash_table_core_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_key(i_key), .o_done(o_done), .o_result(o_result),
        .fail_count(fail_count), .pending_count(pending_count),
        .stored_count(stored_count), .full_count(full_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // present one item after a random gap, hold until taken
    task automatic send_point(input chd_pkg::t_key k, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_key <= k;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        known.push_back(k);
    endtask

    // stop sending and wait until every expected result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // new key, repeat of a known key, or a near neighbor
    function automatic chd_pkg::t_key pick_point(input int mode);
        chd_pkg::t_key k;
        k = '{rand64(), rand64(), rand64()};
        if (mode == 1 && known.size() > 0)
            k = known[$urandom_range(0, known.size() - 1)];
        else if (mode == 2) begin
            k.coord_x = 64'($signed($urandom_range(0, 15)) - 8);
            k.coord_y = 64'($signed($urandom_range(0, 15)) - 8);
            k.coord_z = 64'($signed($urandom_range(0, 3)));
        end
        return k;
    endfunction

    initial begin
        chd_pkg::t_key k;
        int            sent;
        int            quiet;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and repeats
        send_point('{64'sh8000000000000000, 64'sh7fffffffffffffff, 64'sd0}, 0);
        send_point('{64'sh7fffffffffffffff, 64'sh8000000000000000, -64'sd1}, 0);
        send_point('{'1, '1, '1}, 1);
        send_point('{'0, '0, '0}, 1);
        send_point('{'0, '0, '0}, 1);
        send_point('{'1, '1, '1}, 0);
        send_point('{64'sh8000000000000000, 64'sh7fffffffffffffff, 64'sd0}, 0);
        for (int i = 0; i < 8; i++) send_point('{64'sd1 << (i * 8), 64'sd0, 64'sd0}, 0);
        send_point('{64'sd1, 64'sd0, 64'sd0}, 1);

        // sender holds off until everything is back
        drain();

        // random: fresh keys, repeats and clustered neighbors
        sent = 0;
        quiet = 0;
        while (sent < 650) begin
            int r;
            r = $urandom_range(0, 99);
            k = pick_point(r < 55 ? 0 : (r < 85 ? 1 : 2));
            quiet = (quiet > 0) ? quiet - 1 : ($urandom_range(0, 9) == 0 ? 20 : 0);
            send_point(k, quiet > 0);
            sent++;
            // near the load limit, half the time add a repeat to check lookups still hit
            if (stored_count * 10 >= chd_pkg::TABLE_SIZE * 7 - 10 && $urandom_range(0, 1))
                send_point(pick_point(1), 0);
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("lookups sent: %0d random after directed, %0d keys stored, %0d refused",
                 sent, stored_count, full_count);
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/chd_pkg.sv
hdl/chd_ram.sv
hdl/chd_hash.sv
hdl/coordinate_dedup_hash_table_core.sv
dv/coordinate_dedup_hash_table_core_chk.sv
dv/coordinate_dedup_hash_table_core_tb.sv
